@@ src/gpi_pkg.sv @@
// Shared types, constants and the initial-letter lookup for the GB2312 pinyin initial block.
package gpi_pkg;

  localparam int unsigned SpanCount = 23;
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW = $clog2(QueueDepth);
  localparam int unsigned QueueCntW = $clog2(QueueDepth + 1);

  localparam logic [7:0] HighBit = 8'h80;
  localparam logic [15:0] CodeFirst = 16'hB0A1;
  localparam logic [15:0] CodeLast = 16'hD7F9;

  // Lower bound of each letter span; the spans are contiguous up to CodeLast.
  localparam logic [15:0] SpanLo [SpanCount] = '{
    16'hB0A1, 16'hB0C5, 16'hB2C1, 16'hB4EE, 16'hB6EA, 16'hB7A2, 16'hB8C1, 16'hB9FE,
    16'hBBF7, 16'hBFA6, 16'hC0AC, 16'hC2E8, 16'hC4C3, 16'hC5B6, 16'hC5BE, 16'hC6DA,
    16'hC8BB, 16'hC8F6, 16'hCBFA, 16'hCDDA, 16'hCEF4, 16'hD1B9, 16'hD4D1
  };

  // ASCII lower-case letters a..z without i, u and v.
  localparam logic [7:0] SpanLetter [SpanCount] = '{
    8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66, 8'h67, 8'h68,
    8'h6A, 8'h6B, 8'h6C, 8'h6D, 8'h6E, 8'h6F, 8'h70, 8'h71,
    8'h72, 8'h73, 8'h74, 8'h77, 8'h78, 8'h79, 8'h7A
  };

  typedef enum logic [1:0] {
    KIND_ASCII  = 2'd0,
    KIND_CODE   = 2'd1,
    KIND_ORPHAN = 2'd2
  } req_kind_e;

  typedef struct packed {
    req_kind_e   kind;
    logic [15:0] code;
    logic        last;
  } req_t;

  // Returns the initial letter of a double-byte code, or zero outside all spans.
  function automatic logic [7:0] initial_of(input logic [15:0] code);
    logic [7:0] letter;
    letter = '0;
    if (code >= CodeFirst && code <= CodeLast) begin
      for (int k = 0; k < SpanCount; k++) begin
        if (code >= SpanLo[k]) begin
          letter = SpanLetter[k];
        end
      end
    end
    return letter;
  endfunction

endpackage

@@ src/gb2312_pinyin_initial_core.sv @@
// Top level of the GB2312 pinyin initial extractor.
//
// The slave stream takes one GB2312 byte per request in s_axis_tdata_i, with
// s_axis_tlast_i marking the final byte of a string. A byte with bit 7 clear
// leaves as it is; a byte with bit 7 set is held and joined with the next byte
// into a double-byte code whose lower-case pinyin initial leaves on the master
// stream. m_axis_tuser_o flags a code that falls in no span (letter zero), and
// m_axis_tlast_o closes the string. A held lead byte gives no result; a lead
// byte that carries the end mark gives one unmatched result by itself.
//
// One byte is taken every cycle while s_axis_tready_o is high. A result passes
// through the two-entry request queue and then the registered lookup stage
// before it can be taken. When the master side stalls, the queue fills and
// s_axis_tready_o drops once both entries are taken. Reset empties the queue,
// drops the held lead byte and clears the output valid.
module gb2312_pinyin_initial_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] byte_in
  input  logic       s_axis_tlast_i,
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [7:0] letter_code
  output logic       m_axis_tuser_o,   // [0] unmatched
  output logic       m_axis_tlast_o
);

  logic          push_valid, push_ready;
  gpi_pkg::req_t push_req;
  logic          pop_valid, pop_ready;
  gpi_pkg::req_t pop_req;

  gpi_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_byte_i    (s_axis_tdata_i),
    .in_last_i    (s_axis_tlast_i),
    .in_ready_o   (s_axis_tready_o),
    .push_valid_o (push_valid),
    .push_req_o   (push_req),
    .push_ready_i (push_ready)
  );

  gpi_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_req_i   (push_req),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_req_o    (pop_req),
    .pop_ready_i  (pop_ready)
  );

  gpi_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .req_valid_i     (pop_valid),
    .req_i           (pop_req),
    .req_ready_o     (pop_ready),
    .out_valid_o     (m_axis_tvalid_o),
    .out_letter_o    (m_axis_tdata_o),
    .out_unmatched_o (m_axis_tuser_o),
    .out_last_o      (m_axis_tlast_o),
    .out_ready_i     (m_axis_tready_i)
  );

endmodule

@@ src/gpi_front.sv @@
// Front end: accepts bytes, pairs lead and trail bytes and classifies each request.
module gpi_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic [7:0]    in_byte_i,
  input  logic          in_last_i,
  output logic          in_ready_o,
  output logic          push_valid_o,
  output gpi_pkg::req_t push_req_o,
  input  logic          push_ready_i
);

  logic       accept;
  logic       lead_pending_q, lead_pending_d;
  logic [7:0] held_q, held_d;

  assign in_ready_o = push_ready_i;
  assign accept = in_valid_i & push_ready_i;

  always_comb begin
    lead_pending_d = lead_pending_q;
    held_d = held_q;
    push_valid_o = 1'b0;
    push_req_o.kind = gpi_pkg::KIND_ASCII;
    push_req_o.code = {held_q, in_byte_i};
    push_req_o.last = in_last_i;
    if (accept) begin
      if (lead_pending_q) begin
        // Any byte after a lead byte is its trail byte.
        push_valid_o = 1'b1;
        push_req_o.kind = gpi_pkg::KIND_CODE;
        lead_pending_d = 1'b0;
      end else if ((in_byte_i & gpi_pkg::HighBit) == 8'h00) begin
        push_valid_o = 1'b1;
      end else if (in_last_i) begin
        push_valid_o = 1'b1;
        push_req_o.kind = gpi_pkg::KIND_ORPHAN;
      end else begin
        lead_pending_d = 1'b1;
        held_d = in_byte_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lead_pending_q <= 1'b0;
    end else begin
      lead_pending_q <= lead_pending_d;
    end
  end

  always_ff @(posedge clk_i) begin
    held_q <= held_d;
  end

endmodule

@@ src/gpi_queue.sv @@
// Short request queue between the front end and the lookup stage.
module gpi_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  input  gpi_pkg::req_t push_req_i,
  output logic          push_ready_o,
  output logic          pop_valid_o,
  output gpi_pkg::req_t pop_req_o,
  input  logic          pop_ready_i
);

  gpi_pkg::req_t                   slot_q [gpi_pkg::QueueDepth];
  logic [gpi_pkg::QueuePtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [gpi_pkg::QueuePtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [gpi_pkg::QueueCntW-1:0]   count_q, count_d;
  logic                            do_push, do_pop;

  assign push_ready_o = (count_q != gpi_pkg::QueueCntW'(gpi_pkg::QueueDepth));
  assign pop_valid_o = (count_q != '0);
  assign pop_req_o = slot_q[rd_ptr_q];
  assign do_push = push_valid_i & push_ready_o;
  assign do_pop = pop_valid_o & pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == gpi_pkg::QueuePtrW'(gpi_pkg::QueueDepth - 1)) ? '0
               : wr_ptr_q + gpi_pkg::QueuePtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == gpi_pkg::QueuePtrW'(gpi_pkg::QueueDepth - 1)) ? '0
               : rd_ptr_q + gpi_pkg::QueuePtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + gpi_pkg::QueueCntW'(1);
    end else if (!do_push && do_pop) begin
      count_d = count_q - gpi_pkg::QueueCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_req_i;
    end
  end

endmodule

@@ src/gpi_back.sv @@
// Back end: range lookup of double-byte codes and the registered result stage.
module gpi_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  input  gpi_pkg::req_t req_i,
  output logic          req_ready_o,
  output logic          out_valid_o,
  output logic [7:0]    out_letter_o,
  output logic          out_unmatched_o,
  output logic          out_last_o,
  input  logic          out_ready_i
);

  logic       out_valid_q;
  logic [7:0] letter_q, letter_d;
  logic       unmatched_q, unmatched_d;
  logic       last_q;
  logic [7:0] lookup;
  logic       load;

  assign req_ready_o = !out_valid_q || out_ready_i;
  assign load = req_valid_i & req_ready_o;
  assign lookup = gpi_pkg::initial_of(req_i.code);

  always_comb begin
    case (req_i.kind)
      gpi_pkg::KIND_ASCII: begin
        letter_d = req_i.code[7:0];
        unmatched_d = 1'b0;
      end
      gpi_pkg::KIND_CODE: begin
        letter_d = lookup;
        unmatched_d = (lookup == 8'h00);
      end
      default: begin
        letter_d = 8'h00;
        unmatched_d = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (req_ready_o) begin
      out_valid_q <= req_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      letter_q <= letter_d;
      unmatched_q <= unmatched_d;
      last_q <= req_i.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_letter_o = letter_q;
  assign out_unmatched_o = unmatched_q;
  assign out_last_o = last_q;

endmodule
